// ===== design/wcts_pkg.sv =====
package wcts_pkg;

	localparam int STRIP_W = 16;
	localparam int NUM_W   = 29;
	localparam int PADDR_W = 4;

	localparam logic [1:0] REG_VIEW_ROWS  = 2'd0;
	localparam logic [1:0] REG_GRID_PITCH = 2'd1;
	localparam logic [1:0] REG_FOCAL_LEN  = 2'd2;

	localparam logic [10:0] VIEW_ROWS_RST  = 11'd600;
	localparam logic [8:0]  GRID_PITCH_RST = 9'd64;
	localparam logic [11:0] FOCAL_LEN_RST  = 12'd692;

	localparam logic [31:0] ALPHA_MASK = 32'hFF000000;
	localparam logic [31:0] RGB_HALF_MASK = 32'h007F7F7F;

	typedef struct packed {
		logic [10:0] view_rows;
		logic [8:0]  grid_pitch;
		logic [11:0] focal_len;
	} cfg_t;

	typedef struct packed {
		logic        req;
		logic [9:0]  column;
		logic [9:0]  row;
		logic [23:0] ray_len;
		logic [15:0] hit;
		logic        vert;
		logic        tex_ok;
		logic [3:0]  tex_num;
		logic [11:0] tindex;
		logic [31:0] tvalue;
	} req_t;

	typedef struct packed {
		req_t             it;
		logic [STRIP_W-1:0] strip;
		logic [8:0]       hmod;
	} sdiv_t;

	typedef struct packed {
		req_t       it;
		logic       in_strip;
		logic       go;
		logic [7:0] tx;
		logic [7:0] ty;
	} tyd_t;

	function automatic logic [31:0] halve_rgb(input logic [31:0] c);
		return (c & ALPHA_MASK) | ((c >> 1) & RGB_HALF_MASK);
	endfunction

endpackage

// ===== design/wcts_strip_div.sv =====
module wcts_strip_div (
	input  logic            clk,
	input  logic            arst_n,
	input  wcts_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  wcts_pkg::req_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output wcts_pkg::sdiv_t out_item
);
	import wcts_pkg::*;

	localparam int NS = STRIP_W + 2;

	typedef struct packed {
		req_t               it;
		logic               sat;
		logic [NUM_W-1:0]   nrem;
		logic [STRIP_W-1:0] quo;
		logic [15:0]        hrem;
	} sd_stage_t;

	sd_stage_t       stg_s [NS];
	sd_stage_t       nxt [NS];
	logic [NS-1:0]   vld_s;
	logic [NS-1:0]   en;

	// ready ripples back through empty stages
	always_comb begin
		en[NS-1] = !vld_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_comb begin
		logic [39:0] dsh;
		logic [23:0] tsh;
		logic [20:0] prod;
		int          b;
		prod = 21'(cfg.grid_pitch) * 21'(cfg.focal_len);
		nxt[0]      = '0;
		nxt[0].it   = in_item;
		nxt[0].nrem = {prod, 8'b0};
		nxt[0].hrem = in_item.hit;
		nxt[1]      = stg_s[0];
		nxt[1].sat  = (stg_s[0].it.ray_len == 24'd0) ||
			({11'b0, stg_s[0].nrem} >= {stg_s[0].it.ray_len, 16'b0});
		// one quotient bit per stage, MSB first
		for (int k = 2; k < NS; k++) begin
			b      = NS - 1 - k;
			nxt[k] = stg_s[k-1];
			dsh    = {16'b0, stg_s[k-1].it.ray_len} << b;
			if ({11'b0, stg_s[k-1].nrem} >= dsh) begin
				nxt[k].nrem   = stg_s[k-1].nrem - dsh[NUM_W-1:0];
				nxt[k].quo[b] = 1'b1;
			end
			tsh = {15'b0, cfg.grid_pitch} << b;
			if ({8'b0, stg_s[k-1].hrem} >= tsh) begin
				nxt[k].hrem = stg_s[k-1].hrem - tsh[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (en[k]) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

	assign out_valid      = vld_s[NS-1];
	assign out_item.it    = stg_s[NS-1].it;
	assign out_item.strip = stg_s[NS-1].sat ? {STRIP_W{1'b1}} : stg_s[NS-1].quo;
	assign out_item.hmod  = (cfg.grid_pitch == 9'd0) ? 9'd0 : stg_s[NS-1].hrem[8:0];

endmodule

// ===== design/wcts_ty_div.sv =====
module wcts_ty_div #(
	parameter int TEX_WIDTH  = 64,
	parameter int TEX_HEIGHT = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wcts_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  wcts_pkg::sdiv_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output wcts_pkg::tyd_t  out_item
);
	import wcts_pkg::*;

	localparam int QB = $clog2(TEX_HEIGHT);
	localparam int NS = QB + 1;

	typedef struct packed {
		req_t               it;
		logic               in_strip;
		logic               go;
		logic [7:0]         tx;
		logic [STRIP_W-1:0] strip;
		logic [24:0]        trem;
		logic [7:0]         ty;
	} ty_stage_t;

	ty_stage_t     stg_s [NS];
	ty_stage_t     nxt [NS];
	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_comb begin
		logic [9:0]  center;
		logic [14:0] half;
		logic [15:0] top;
		logic [15:0] bot;
		logic [16:0] dft;
		logic [12:0] r;
		logic [25:0] ssh;
		int          b;
		center = cfg.view_rows[10:1];
		half   = in_item.strip[15:1];
		if ({6'b0, center} > {1'b0, half}) begin
			top = {6'b0, center} - {1'b0, half};
		end else begin
			top = 16'd0;
		end
		bot = {6'b0, center} + {1'b0, half};
		if (bot > {5'b0, cfg.view_rows}) begin
			bot = {5'b0, cfg.view_rows};
		end
		dft = 17'(in_item.it.row) + 17'(half) - 17'(center);
		// reduce the tile offset to a texture column
		r = {4'b0, in_item.hmod};
		for (int j = 4; j >= 0; j--) begin
			if (r >= 13'(TEX_WIDTH << j)) begin
				r = r - 13'(TEX_WIDTH << j);
			end
		end
		nxt[0]          = '0;
		nxt[0].it       = in_item.it;
		nxt[0].in_strip = ({6'b0, in_item.it.row} >= top) && ({6'b0, in_item.it.row} < bot);
		nxt[0].go       = nxt[0].in_strip && in_item.it.tex_ok && (in_item.strip != '0);
		nxt[0].tx       = r[7:0];
		nxt[0].strip    = in_item.strip;
		nxt[0].trem     = 25'(dft * TEX_HEIGHT);
		for (int k = 1; k < NS; k++) begin
			b      = QB - k;
			nxt[k] = stg_s[k-1];
			ssh    = {10'b0, stg_s[k-1].strip} << b;
			if ({1'b0, stg_s[k-1].trem} >= ssh) begin
				nxt[k].trem  = stg_s[k-1].trem - ssh[24:0];
				nxt[k].ty[b] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (en[k]) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

	assign out_valid         = vld_s[NS-1];
	assign out_item.it       = stg_s[NS-1].it;
	assign out_item.in_strip = stg_s[NS-1].in_strip;
	assign out_item.go       = stg_s[NS-1].go;
	assign out_item.tx       = stg_s[NS-1].tx;
	assign out_item.ty       = stg_s[NS-1].ty;

endmodule

// ===== design/wcts_tex_mem.sv =====
module wcts_tex_mem #(
	parameter int TEX_WIDTH    = 64,
	parameter int TEX_HEIGHT   = 64,
	parameter int NUM_TEXTURES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  wcts_pkg::tyd_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [9:0]     pixel_x,
	output logic [9:0]     pixel_y,
	output logic [31:0]    pixel_color,
	output logic           in_wall
);
	import wcts_pkg::*;

	localparam int TEX_SIZE = TEX_WIDTH * TEX_HEIGHT;
	localparam int DEPTH    = NUM_TEXTURES * TEX_SIZE;
	localparam int AW       = $clog2(DEPTH);

	logic [31:0]   mem [DEPTH];

	logic          vld_s1, vld_s2, vld_s3;
	logic          en1, en2, en3;
	tyd_t          it_s1, it_s2;
	logic [AW-1:0] addr_s1;
	logic          we_s1;
	logic [31:0]   rd_s2;
	logic [9:0]    px_s3, py_s3;
	logic [31:0]   col_s3;
	logic          inw_s3;

	logic [7:0]    tyc;
	logic [AW-1:0] raddr, waddr;
	logic          we;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		tyc   = (9'(in_item.ty) >= 9'(TEX_HEIGHT)) ? 8'(TEX_HEIGHT - 1) : in_item.ty;
		raddr = AW'(in_item.it.tex_num * TEX_SIZE + tyc * TEX_WIDTH + in_item.tx);
		waddr = AW'(in_item.it.tex_num * TEX_SIZE + in_item.it.tindex);
		we    = in_item.it.req && in_item.it.tex_ok &&
			(17'(in_item.it.tindex) < 17'(TEX_SIZE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= in_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			// write words end here and give no pixel
			if (en3) begin
				vld_s3 <= vld_s2 && !it_s2.it.req;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			it_s1   <= in_item;
			addr_s1 <= in_item.it.req ? waddr : raddr;
			we_s1   <= we;
		end
		if (en2) begin
			it_s2 <= it_s1;
		end
		if (en3) begin
			px_s3  <= it_s2.it.column;
			py_s3  <= it_s2.it.row;
			inw_s3 <= it_s2.in_strip;
			if (!it_s2.go) begin
				col_s3 <= 32'd0;
			end else if (it_s2.it.vert) begin
				col_s3 <= halve_rgb(rd_s2);
			end else begin
				col_s3 <= rd_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			if (we_s1) begin
				mem[addr_s1] <= it_s1.it.tvalue;
			end else begin
				rd_s2 <= mem[addr_s1];
			end
		end
	end

	assign out_valid   = vld_s3;
	assign pixel_x     = px_s3;
	assign pixel_y     = py_s3;
	assign pixel_color = col_s3;
	assign in_wall     = inw_s3;

endmodule

// ===== design/wall_column_texel_shader.sv =====
// Textured wall column shader: one screen pixel per render word.
// Input channel (in_valid/in_ready) carries render words (req_type 0) and
// texel write words (req_type 1). A write word loads one ARGB texel into the
// texture store and yields no output; a render word yields exactly one pixel
// word on the output channel (out_valid/out_ready) in the order taken.
// A texel must be written before any pixel reads it.
// The pipeline has 18 stages for the strip height division (one quotient
// bit per stage, alongside the hit-modulo-tile reduction), one geometry
// stage, clog2(TEX_HEIGHT) stages for the texture row division, then
// address, memory read and shading. Throughput is one word per cycle
// while out_ready holds high; the single texture store port serves
// either the write or the read of the word passing through it.
// When the receiver stalls, words pile up into empty stages and in_ready
// falls only once every stage is full; nothing is lost or repeated.
// Reset clears the stage valid bits and loads the configuration defaults
// (screen 600, tile 64, plane 692); the texture store is not cleared.
// Configuration is written over the APB port at 0x0, 0x4 and 0x8; the user
// must do so only while the pipeline is empty (the block does not enforce it).
module wall_column_texel_shader #(
	parameter int TEX_WIDTH    = 64,
	parameter int TEX_HEIGHT   = 64,
	parameter int NUM_TEXTURES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wcts_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [9:0]                  column,
	input  logic [9:0]                  row,
	input  logic [23:0]                 ray_dist,
	input  logic [15:0]                 hit_x,
	input  logic [15:0]                 hit_y,
	input  logic                        hit_vertical,
	input  logic [3:0]                  wall_content,
	input  logic [11:0]                 texel_index,
	input  logic [31:0]                 texel_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [9:0]                  pixel_x,
	output logic [9:0]                  pixel_y,
	output logic [31:0]                 pixel_color,
	output logic                        in_wall
);
	import wcts_pkg::*;

	logic [10:0] view_rows_q;
	logic [8:0]  grid_pitch_q;
	logic [11:0] focal_len_q;
	cfg_t        cfg;

	req_t        in_item;
	logic        tex_ok;
	sdiv_t       sd_item;
	logic        sd_valid, sd_ready;
	tyd_t        ty_item;
	logic        ty_valid, ty_ready;

	assign pready = 1'b1;

	// register writes land on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_rows_q  <= VIEW_ROWS_RST;
			grid_pitch_q <= GRID_PITCH_RST;
			focal_len_q  <= FOCAL_LEN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_VIEW_ROWS:  view_rows_q  <= pwdata[10:0];
				REG_GRID_PITCH: grid_pitch_q <= pwdata[8:0];
				REG_FOCAL_LEN:  focal_len_q  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_VIEW_ROWS:  prdata = {21'b0, view_rows_q};
			REG_GRID_PITCH: prdata = {23'b0, grid_pitch_q};
			REG_FOCAL_LEN:  prdata = {20'b0, focal_len_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg.view_rows  = view_rows_q;
	assign cfg.grid_pitch = grid_pitch_q;
	assign cfg.focal_len  = focal_len_q;

	// decode the texture number; an unknown wall type maps to texture 0 but
	// is flagged so that it never writes the store and its pixel colour is zero
	assign tex_ok = (wall_content != 4'd0) && (5'(wall_content) <= 5'(NUM_TEXTURES));

	always_comb begin
		in_item.req     = req_type;
		in_item.column  = column;
		in_item.row     = row;
		in_item.ray_len = ray_dist;
		in_item.hit     = hit_vertical ? hit_y : hit_x;
		in_item.vert    = hit_vertical;
		in_item.tex_ok  = tex_ok;
		in_item.tex_num = tex_ok ? wall_content - 4'd1 : 4'd0;
		in_item.tindex  = texel_index;
		in_item.tvalue  = texel_value;
	end

	wcts_strip_div u_strip_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(sd_valid),
		.out_ready(sd_ready),
		.out_item (sd_item)
	);

	wcts_ty_div #(
		.TEX_WIDTH (TEX_WIDTH),
		.TEX_HEIGHT(TEX_HEIGHT)
	) u_ty_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (sd_valid),
		.in_ready (sd_ready),
		.in_item  (sd_item),
		.out_valid(ty_valid),
		.out_ready(ty_ready),
		.out_item (ty_item)
	);

	wcts_tex_mem #(
		.TEX_WIDTH   (TEX_WIDTH),
		.TEX_HEIGHT  (TEX_HEIGHT),
		.NUM_TEXTURES(NUM_TEXTURES)
	) u_tex_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ty_valid),
		.in_ready   (ty_ready),
		.in_item    (ty_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.in_wall    (in_wall)
	);

endmodule

// ===== dv/tb_wall_column_texel_shader.sv =====
module tb_wall_column_texel_shader;
	import wcts_pkg::*;

	localparam int TEX_W     = 64;
	localparam int TEX_H     = 64;
	localparam int NUM_TEX   = 8;
	localparam int TEX_TEXELS = TEX_W * TEX_H;
	localparam int STORE_LEN = NUM_TEX * TEX_TEXELS;
	// Settle margin beyond the pipeline latency.
	localparam int SETTLE    = 60;
	localparam int CYCLE_CAP = 3000000;

	localparam logic REQ_RENDER = 1'b0;
	localparam logic REQ_WRITE  = 1'b1;

	typedef struct packed {
		logic [9:0]  px;
		logic [9:0]  py;
		logic [31:0] color;
		logic        wall;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic [9:0] column = '0, row = '0;
	logic [23:0] ray_dist = '0;
	logic [15:0] hit_x = '0, hit_y = '0;
	logic hit_vertical = 1'b0;
	logic [3:0] wall_content = 4'd1;
	logic [11:0] texel_index = '0;
	logic [31:0] texel_value = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [9:0] pixel_x, pixel_y;
	logic [31:0] pixel_color;
	logic in_wall;

	// Our own copy of the configuration and the texture store.
	logic [10:0] cur_height = 11'd600;
	logic [8:0]  cur_tile   = 9'd64;
	logic [11:0] cur_plane  = 12'd692;
	logic [31:0] texels [STORE_LEN];
	bit          written [STORE_LEN];

	pixel_t pixel_due [$];
	int     fails = 0;
	int     cycles = 0;
	int     sent = 0;
	bit     idling = 1'b1;

	wall_column_texel_shader DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .column(column), .row(row), .ray_dist(ray_dist),
		.hit_x(hit_x), .hit_y(hit_y), .hit_vertical(hit_vertical),
		.wall_content(wall_content), .texel_index(texel_index),
		.texel_value(texel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
		.in_wall(in_wall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Store slot a render word reads, or -1 when it reads nothing.
	function automatic int texel_slot(logic [9:0] r, logic [23:0] d, logic [15:0] hx,
			logic [15:0] hy, logic v, logic [3:0] wc, output bit wall);
		longint num, strip, half, center, top, bottom, hit, tx, dft, ty;
		bit ok;
		num = longint'(cur_tile) * longint'(cur_plane) * 256;
		strip = (d == 0) ? 65535 : num / longint'(d);
		if (strip > 65535)
			strip = 65535;
		half = strip / 2;
		center = longint'(cur_height) / 2;
		top = center - half;
		bottom = center + half;
		if (top < 0)
			top = 0;
		if (bottom > longint'(cur_height))
			bottom = longint'(cur_height);
		ok = (wc >= 1) && (wc <= NUM_TEX);
		wall = (longint'(r) >= top) && (longint'(r) < bottom);
		if (!(wall && ok && strip != 0))
			return -1;
		hit = v ? longint'(hy) : longint'(hx);
		tx = (cur_tile != 0) ? (hit % longint'(cur_tile)) % TEX_W : 0;
		dft = longint'(r) + half - center;
		ty = dft * TEX_H / strip;
		if (ty >= TEX_H)
			ty = TEX_H - 1;
		return int'((longint'(wc) - 1) * TEX_TEXELS + ty * TEX_W + tx);
	endfunction

	// Work out the shaded pixel for one render word from the current state.
	function automatic pixel_t shade_pixel(logic [9:0] c, logic [9:0] r, logic [23:0] d,
			logic [15:0] hx, logic [15:0] hy, logic v, logic [3:0] wc);
		pixel_t p;
		int slot;
		bit wall;
		logic [31:0] col;
		slot = texel_slot(r, d, hx, hy, v, wc, wall);
		col = '0;
		if (slot >= 0) begin
			col = texels[slot];
			// vertical sides: halve R, G and B, keep alpha
			if (v)
				col = (col & 32'hFF000000) | ((col >> 1) & 32'h007F7F7F);
		end
		p.px = c;
		p.py = r;
		p.wall = wall;
		p.color = col;
		return p;
	endfunction

	// Drive one word at the falling edge, hold it until taken, then record the
	// expectation. A random gap in front of the word lowers valid first.
	task automatic send_word(logic rt, logic [9:0] c, logic [9:0] r, logic [23:0] d,
			logic [15:0] hx, logic [15:0] hy, logic v, logic [3:0] wc,
			logic [11:0] ti, logic [31:0] tv);
		int gap;
		gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = rt; column = c; row = r; ray_dist = d; hit_x = hx; hit_y = hy;
		hit_vertical = v; wall_content = wc; texel_index = ti; texel_value = tv;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if (rt == REQ_WRITE) begin
			if (wc >= 1 && wc <= NUM_TEX) begin
				texels[(int'(wc) - 1) * TEX_TEXELS + int'(ti)] = tv;
				written[(int'(wc) - 1) * TEX_TEXELS + int'(ti)] = 1'b1;
			end
		end else begin
			pixel_due.push_back(shade_pixel(c, r, d, hx, hy, v, wc));
		end
	endtask

	// Drop valid and wait until the pipeline has emptied.
	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		while (pixel_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_VIEW_ROWS:  cur_height = val[10:0];
			REG_GRID_PITCH: cur_tile = val[8:0];
			REG_FOCAL_LEN:  cur_plane = val[11:0];
			default: ;
		endcase
	endtask

	task automatic set_view(int h, int t, int p);
		drain();
		write_reg(REG_VIEW_ROWS, 32'(h));
		write_reg(REG_GRID_PITCH, 32'(t));
		write_reg(REG_FOCAL_LEN, 32'(p));
	endtask

	// Send a render word; a texel it reads that was never loaded is written
	// just before it.
	task automatic render(logic [9:0] c, logic [9:0] r, logic [23:0] d,
			logic [15:0] hx, logic [15:0] hy, logic v, logic [3:0] wc);
		int slot;
		bit wall;
		slot = texel_slot(r, d, hx, hy, v, wc, wall);
		if (slot >= 0 && !written[slot])
			send_word(REQ_WRITE, c, r, d, hx, hy, v, 4'(slot / TEX_TEXELS + 1),
				12'(slot % TEX_TEXELS), $urandom);
		send_word(REQ_RENDER, c, r, d, hx, hy, v, wc, 12'($urandom), $urandom);
	endtask

	task automatic test_directed;
		// texel extremes, then writes to missing textures that must be ignored
		send_word(REQ_WRITE, 10'd0, 10'd0, 24'd0, 16'd0, 16'd0, 1'b0, 4'd1, 12'd0,
			32'hFFFFFFFF);
		send_word(REQ_WRITE, 10'd0, 10'd0, 24'd0, 16'd0, 16'd0, 1'b0, 4'd8, 12'd4095,
			32'h00000000);
		send_word(REQ_WRITE, 10'h3FF, 10'h3FF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			4'd0, 12'd5, 32'h12345678);
		send_word(REQ_WRITE, 10'd0, 10'd0, 24'd0, 16'd0, 16'd0, 1'b0, 4'd15, 12'd5,
			32'h89ABCDEF);
		render(10'd0, 10'd0, 24'd0, 16'd0, 16'd0, 1'b0, 4'd1);        // zero distance, top row
		render(10'h3FF, 10'd299, 24'd0, 16'hFFFF, 16'hFFFF, 1'b1, 4'd8);
		render(10'd5, 10'd599, 24'd0, 16'd0, 16'd63, 1'b1, 4'd1);
		render(10'd6, 10'd600, 24'd0, 16'd1, 16'd0, 1'b0, 4'd1);      // just below the screen bottom row
		render(10'd7, 10'h3FF, 24'd100, 16'd3, 16'd4, 1'b0, 4'd2);    // far below the screen
		render(10'd8, 10'd300, 24'hFFFFFF, 16'd3, 16'd4, 1'b0, 4'd2); // no strip at all
		render(10'd9, 10'd300, 24'd1, 16'd3, 16'd4, 1'b1, 4'd3);
		render(10'd10, 10'd300, 24'd45000, 16'd77, 16'd99, 1'b0, 4'd0); // missing texture
		render(10'd11, 10'd301, 24'd45000, 16'd77, 16'd99, 1'b1, 4'd9);
		render(10'd12, 10'd280, 24'd45000, 16'd77, 16'd99, 1'b1, 4'd15);
		render(10'd13, 10'd250, 24'd20000, 16'hFFFF, 16'h0000, 1'b0, 4'd4);
		render(10'd14, 10'd350, 24'd20000, 16'h0000, 16'hFFFF, 1'b1, 4'd5);
	endtask

	task automatic random_word;
		int mode, s, row_pick;
		longint num, d;
		logic [3:0] wc;
		if ($urandom_range(0, 4) == 0) begin
			wc = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, NUM_TEX));
			send_word(REQ_WRITE, 10'($urandom), 10'($urandom), 24'($urandom),
				16'($urandom), 16'($urandom), 1'($urandom), wc, 12'($urandom), $urandom);
			return;
		end
		num = longint'(cur_tile) * longint'(cur_plane) * 256;
		mode = $urandom_range(0, 9);
		if (mode == 0)
			d = 0;
		else if (mode == 1)
			d = $urandom_range(0, 24'hFFFFFF);
		else begin
			// aim the strip at a size comparable with the screen
			s = $urandom_range(1, 2 * cur_height + 2);
			d = num / s + $urandom_range(0, 3);
			if (d > 24'hFFFFFF)
				d = 24'hFFFFFF;
		end
		wc = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, NUM_TEX));
		row_pick = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1023)) :
			int'($urandom_range(0, cur_height + 4));
		if (row_pick > 1023)
			row_pick = 1023;
		render(10'($urandom), 10'(row_pick), 24'(d), 16'($urandom), 16'($urandom),
			1'($urandom), wc);
	endtask

	task automatic test_random;
		int settings [6][3] = '{'{600, 64, 692}, '{2, 1, 1}, '{1024, 256, 4095},
			'{480, 16, 277}, '{1023, 255, 4094}, '{768, 128, 1500}};
		int start;
		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 6)
				set_view(settings[ph][0], settings[ph][1], settings[ph][2]);
			else
				set_view($urandom_range(2, 1024), $urandom_range(1, 256),
					$urandom_range(1, 4095));
			// calm tail with no idling on either side
			if (ph == 8)
				idling = 1'b0;
			start = sent;
			while (sent - start < 100)
				random_word();
		end
	endtask

	// Receiver back-pressure in bursts.
	initial begin
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 9) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	// Compare each delivered pixel word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pixel_due.size() == 0) begin
				$error("pixel word with nothing expected: x %0d y %0d", pixel_x, pixel_y);
				fails++;
			end else begin
				pixel_t e;
				e = pixel_due.pop_front();
				if (pixel_x !== e.px) begin
					$error("pixel_x expected %0d got %0d", e.px, pixel_x);
					fails++;
				end
				if (pixel_y !== e.py) begin
					$error("pixel_y expected %0d got %0d", e.py, pixel_y);
					fails++;
				end
				if (pixel_color !== e.color) begin
					$error("pixel_color expected %h got %h", e.color, pixel_color);
					fails++;
				end
				if (in_wall !== e.wall) begin
					$error("in_wall expected %0d got %0d", e.wall, in_wall);
					fails++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		drain();
		if (fails == 0 && pixel_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
